### rtl/tx_byte_ring_chunked_drain_assert.svh
// Assertion macros for the transmit byte ring.
`ifndef TX_BYTE_RING_CHUNKED_DRAIN_ASSERT_SVH
`define TX_BYTE_RING_CHUNKED_DRAIN_ASSERT_SVH

// Same-cycle implication.
`define TBRCD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbrcd assertion failed");

// Next-cycle implication.
`define TBRCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbrcd assertion failed");

`endif

### rtl/tbrcd_pkg.sv
package tbrcd_pkg;

    localparam int RING_BYTES_DEF  = 1024;
    localparam int MAX_CHUNKS_DEF  = 4;
    localparam int MAX_PAYLOAD_DEF = 514;

    localparam int ADDR_MAX_W = 16;
    localparam int KIND_W     = 3;
    localparam int WLEN_W     = 11;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 10;
    localparam int PEND_W     = 11;
    localparam int MTU_W      = 10;
    localparam int CHUNK_CNT_W = 4;

    localparam logic [MTU_W-1:0] MTU_RESET         = 10'd23;
    localparam logic [MTU_W-1:0] MTU_CEILING       = 10'd517;
    localparam logic [MTU_W-1:0] MTU_OVERHEAD      = 10'd3;
    localparam logic [LEN_W-1:0] SMALL_MTU_PAYLOAD = 10'd20;

    localparam logic [KIND_W-1:0] KIND_WRITE_BEGIN = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE_BYTE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DRAIN_BEGIN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CHUNK_BYTE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHUNK_DONE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESET       = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WLEN_W-1:0] write_length;
        logic [BYTE_W-1:0] data_in;
        logic              handle_valid;
        logic              link_congested;
        logic              send_ok;
    } tbrcd_in_t;

    typedef struct packed {
        logic              accepted;
        logic [LEN_W-1:0]  chunk_length;
        logic [BYTE_W-1:0] data_out;
        logic              chunk_last;
        logic [PEND_W-1:0] pending_bytes;
    } tbrcd_out_t;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_MAX_W-1:0] wr_addr;
        logic [BYTE_W-1:0]     wr_data;
        logic                  rd_en;
        logic [ADDR_MAX_W-1:0] rd_addr;
    } tbrcd_mem_req_t;

    function automatic logic [LEN_W-1:0] payload_limit(
        input logic [MTU_W-1:0] mtu,
        input logic [LEN_W-1:0] max_payload
    );
        logic [MTU_W-1:0] m;
        logic [LEN_W-1:0] p;
        m = (mtu > MTU_CEILING) ? MTU_CEILING : mtu;
        p = (m > MTU_OVERHEAD) ? LEN_W'(m - MTU_OVERHEAD) : SMALL_MTU_PAYLOAD;
        return (p > max_payload) ? max_payload : p;
    endfunction

endpackage

### rtl/tbrcd_ring.sv
module tbrcd_ring
    import tbrcd_pkg::*;
#(
    parameter int RING_BYTES = RING_BYTES_DEF
) (
    input  logic              clk,
    input  tbrcd_mem_req_t    req,
    output logic [BYTE_W-1:0] rd_data
);

    localparam int AW = $clog2(RING_BYTES);

    logic [BYTE_W-1:0] mem [RING_BYTES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr[AW-1:0]];
        end
    end

endmodule

### rtl/tbrcd_ctrl.sv
module tbrcd_ctrl
    import tbrcd_pkg::*;
#(
    parameter int RING_BYTES           = RING_BYTES_DEF,
    parameter int MAX_CHUNKS_PER_DRAIN = MAX_CHUNKS_DEF,
    parameter int MAX_PAYLOAD          = MAX_PAYLOAD_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  tbrcd_in_t        cmd,
    input  logic             cfg_we,
    input  logic [MTU_W-1:0] cfg_data,
    output tbrcd_mem_req_t   mem_req,
    output tbrcd_out_t       result_base,
    output logic             done,
    output logic             rd_flag
);

    localparam int AW = $clog2(RING_BYTES);
    localparam int FW = $clog2(RING_BYTES + 1);
    localparam int CW = (FW > WLEN_W) ? FW : WLEN_W;
    localparam int SW = CW + 1;

    logic [AW-1:0]          head_reg, head_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [FW-1:0]          wrem_reg, wrem_next;
    logic [FW-1:0]          woff_reg, woff_next;
    logic [LEN_W-1:0]       staged_reg, staged_next;
    logic [LEN_W-1:0]       sread_reg, sread_next;
    logic [CHUNK_CNT_W-1:0] chunks_reg, chunks_next;
    logic [MTU_W-1:0]       mtu_reg;
    tbrcd_out_t             result_reg, result_next;
    logic                   done_reg;
    logic                   rd_flag_reg, rd_flag_next;

    logic [LEN_W-1:0] lim;
    logic [FW-1:0]    fill_after;
    tbrcd_mem_req_t   req;

    function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] sum);
        logic [SW-1:0] r;
        r = (sum >= SW'(RING_BYTES)) ? sum - SW'(RING_BYTES) : sum;
        return r[AW-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] stage_len(
        input logic [FW-1:0]    f,
        input logic [LEN_W-1:0] l
    );
        return (CW'(f) < CW'(l)) ? LEN_W'(f) : l;
    endfunction

    assign lim = payload_limit(mtu_reg, LEN_W'(MAX_PAYLOAD));
    assign fill_after = fill_reg - FW'(staged_reg);

    always_comb
    begin
        head_next    = head_reg;
        fill_next    = fill_reg;
        wrem_next    = wrem_reg;
        woff_next    = woff_reg;
        staged_next  = staged_reg;
        sread_next   = sread_reg;
        chunks_next  = chunks_reg;
        rd_flag_next = 1'b0;
        req          = '0;
        result_next  = '0;

        if (accept)
        begin
            unique case (cmd.kind)
                KIND_WRITE_BEGIN:
                begin
                    wrem_next = '0;
                    woff_next = '0;
                    if (CW'(cmd.write_length) <= CW'(RING_BYTES) - CW'(fill_reg))
                    begin
                        result_next.accepted = 1'b1;
                        wrem_next = FW'(cmd.write_length);
                    end
                    result_next.chunk_length = staged_reg;
                end
                KIND_WRITE_BYTE:
                begin
                    if (wrem_reg != '0)
                    begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = ADDR_MAX_W'(ring_wrap(SW'(head_reg) + SW'(fill_reg)
                                                            + SW'(woff_reg)));
                        req.wr_data = cmd.data_in;
                        wrem_next   = wrem_reg - 1'b1;
                        woff_next   = woff_reg + 1'b1;
                        if (wrem_reg == FW'(1))
                        begin
                            fill_next = fill_reg + woff_reg + 1'b1;
                            woff_next = '0;
                        end
                    end
                    result_next.chunk_length = staged_reg;
                end
                KIND_DRAIN_BEGIN:
                begin
                    chunks_next = '0;
                    sread_next  = '0;
                    if (!cmd.handle_valid || cmd.link_congested || fill_reg == '0)
                    begin
                        staged_next = '0;
                    end
                    else
                    begin
                        staged_next = stage_len(fill_reg, lim);
                    end
                    result_next.chunk_length = staged_next;
                end
                KIND_CHUNK_BYTE:
                begin
                    if (sread_reg < staged_reg)
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = ADDR_MAX_W'(ring_wrap(SW'(head_reg) + SW'(sread_reg)));
                        rd_flag_next = 1'b1;
                        result_next.chunk_last = (sread_reg + 1'b1 == staged_reg);
                        sread_next = sread_reg + 1'b1;
                    end
                    result_next.chunk_length = staged_reg;
                end
                KIND_CHUNK_DONE:
                begin
                    if (staged_reg != '0)
                    begin
                        if (cmd.send_ok)
                        begin
                            head_next   = ring_wrap(SW'(head_reg) + SW'(staged_reg));
                            fill_next   = fill_after;
                            chunks_next = chunks_reg + 1'b1;
                            if (chunks_next < CHUNK_CNT_W'(MAX_CHUNKS_PER_DRAIN)
                                && fill_after != '0)
                            begin
                                staged_next = stage_len(fill_after, lim);
                            end
                            else
                            begin
                                staged_next = '0;
                            end
                        end
                        else
                        begin
                            staged_next = '0;
                        end
                        sread_next = '0;
                    end
                    result_next.chunk_length = staged_next;
                end
                KIND_RESET:
                begin
                    head_next   = '0;
                    fill_next   = '0;
                    wrem_next   = '0;
                    woff_next   = '0;
                    staged_next = '0;
                    sread_next  = '0;
                    chunks_next = '0;
                end
                default:
                begin
                end
            endcase
            result_next.pending_bytes = PEND_W'(fill_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            fill_reg    <= '0;
            wrem_reg    <= '0;
            woff_reg    <= '0;
            staged_reg  <= '0;
            sread_reg   <= '0;
            chunks_reg  <= '0;
            mtu_reg     <= MTU_RESET;
            done_reg    <= 1'b0;
            rd_flag_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            wrem_reg    <= wrem_next;
            woff_reg    <= woff_next;
            staged_reg  <= staged_next;
            sread_reg   <= sread_next;
            chunks_reg  <= chunks_next;
            done_reg    <= accept;
            rd_flag_reg <= rd_flag_next;
            if (cfg_we)
            begin
                mtu_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign mem_req     = req;
    assign result_base = result_reg;
    assign done        = done_reg;
    assign rd_flag     = rd_flag_reg;

endmodule

### rtl/tx_byte_ring_chunked_drain.sv
// Transmit byte ring with chunked drain. Every command is taken in one cycle and busy is
// never raised, so start may be held high for a command each cycle. The answer to each
// command appears on result for exactly one cycle, flagged by done, in the cycle after
// the command was taken; it must be captured then. Ring bytes live in a RAM with one write
// and one registered read port: write_byte writes it in the accepting cycle, chunk_byte
// reads it in the accepting cycle and its data_out comes straight from the RAM read
// register. The ring needs no clearing pass after reset, since only written bytes are read.
module tx_byte_ring_chunked_drain
    import tbrcd_pkg::*;
#(
    parameter int RING_BYTES           = RING_BYTES_DEF,
    parameter int MAX_CHUNKS_PER_DRAIN = MAX_CHUNKS_DEF,
    parameter int MAX_PAYLOAD          = MAX_PAYLOAD_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tbrcd_in_t        cmd,
    output logic             done,
    output tbrcd_out_t       result,
    input  logic             cfg_we,
    input  logic [MTU_W-1:0] cfg_data
);

    logic              accept;
    tbrcd_mem_req_t    mem_req;
    tbrcd_out_t        result_base;
    logic              rd_flag;
    logic [BYTE_W-1:0] rd_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    tbrcd_ctrl #(
        .RING_BYTES           (RING_BYTES),
        .MAX_CHUNKS_PER_DRAIN (MAX_CHUNKS_PER_DRAIN),
        .MAX_PAYLOAD          (MAX_PAYLOAD)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .mem_req     (mem_req),
        .result_base (result_base),
        .done        (done),
        .rd_flag     (rd_flag)
    );

    tbrcd_ring #(
        .RING_BYTES (RING_BYTES)
    ) u_ring (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        result = result_base;
        result.data_out = rd_flag ? rd_data : '0;
    end

endmodule

### rtl/tbrcd_checker.sv
`include "tx_byte_ring_chunked_drain_assert.svh"

module tbrcd_checker
    import tbrcd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input tbrcd_in_t  cmd,
    input logic       done,
    input tbrcd_out_t result
);

    `TBRCD_ASSERT_NEXT(a_word_answered, start && !busy, done)
    `TBRCD_ASSERT_NEXT(a_no_stray_done, !(start && !busy), !done)
    `TBRCD_ASSERT_IMP(a_len_bound, done, result.chunk_length <= LEN_W'(MAX_PAYLOAD))
    `TBRCD_ASSERT_IMP(a_accept_src, done && result.accepted, $past(cmd.kind) == KIND_WRITE_BEGIN)
    `TBRCD_ASSERT_IMP(a_last_src, done && result.chunk_last,
        $past(cmd.kind) == KIND_CHUNK_BYTE && result.chunk_length != '0)

endmodule

bind tx_byte_ring_chunked_drain tbrcd_checker #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
) u_tbrcd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
